@@ rtl/core/sip24_pkg.sv @@
// ----------------------------------------------------------------------------
// sip24_pkg
// Shared types, constants and the SipRound function for the SipHash-2-4
// stream hasher.
// ----------------------------------------------------------------------------
package sip24_pkg;

   // Width of one chain value, one message word and the digest.
   localparam int WORD_W = 64;
   // Width of the byte count field and of the byte-length counter.
   localparam int COUNT_W = 4;
   localparam int LEN_W = 8;
   // Bytes in one full message word.
   localparam int WORD_BYTES = 8;

   // Default round counts.
   localparam int DEF_COMPRESS_ROUNDS = 2;
   localparam int DEF_FINAL_ROUNDS = 4;
   // SipRounds done per finalization pipeline stage.
   localparam int ROUNDS_PER_STAGE = 2;

   // Initialization constants xored with the key.
   localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

   // Rotation amounts of one SipRound.
   localparam int ROT_A = 13;
   localparam int ROT_B = 32;
   localparam int ROT_C = 16;
   localparam int ROT_D = 21;
   localparam int ROT_E = 17;

   // Constant xored into v2 before finalization.
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   // Configuration register indexes.
   localparam logic CSR_KEY_LOW = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // The four chain values v0..v3, v0 at index 0.
   typedef logic [3:0][WORD_W-1:0] chain_type;

   // One SipRound over the four chain values.
   function automatic chain_type sip_round(chain_type x);
      chain_type v;
      v = x;
      v[0] = v[0] + v[1];
      v[1] = {v[1][WORD_W-1-ROT_A:0], v[1][WORD_W-1:WORD_W-ROT_A]};
      v[1] = v[1] ^ v[0];
      v[0] = {v[0][WORD_W-1-ROT_B:0], v[0][WORD_W-1:WORD_W-ROT_B]};
      v[2] = v[2] + v[3];
      v[3] = {v[3][WORD_W-1-ROT_C:0], v[3][WORD_W-1:WORD_W-ROT_C]};
      v[3] = v[3] ^ v[2];
      v[0] = v[0] + v[3];
      v[3] = {v[3][WORD_W-1-ROT_D:0], v[3][WORD_W-1:WORD_W-ROT_D]};
      v[3] = v[3] ^ v[0];
      v[2] = v[2] + v[1];
      v[1] = {v[1][WORD_W-1-ROT_E:0], v[1][WORD_W-1:WORD_W-ROT_E]};
      v[1] = v[1] ^ v[2];
      v[2] = {v[2][WORD_W-1-ROT_B:0], v[2][WORD_W-1:WORD_W-ROT_B]};
      return v;
   endfunction

endpackage

@@ rtl/core/siphash_2_4_stream.sv @@
// ----------------------------------------------------------------------------
// siphash_2_4_stream
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// The block takes one message word per cycle while req_tready is high and
// returns one 64-bit digest per message. The rate of one word per cycle is
// set by the chain update, which runs all COMPRESS_ROUNDS SipRounds of a word
// combinationally. The final word of a message is absorbed in the cycle it is
// accepted and registered into the length block stage, which adds the length
// block after a full last word and the v2 tweak; the chain then passes through
// the finalization stages, each running up to two finalization rounds, and the
// digest lands in the output register. Several messages may be in flight in
// the finalization pipeline, and a new message may start with the word right
// after the last word of the previous one. The key is read only at the first
// word of a message, so writing it between messages is enough.
// ----------------------------------------------------------------------------
module siphash_2_4_stream #(
   parameter int COMPRESS_ROUNDS = sip24_pkg::DEF_COMPRESS_ROUNDS,
   parameter int FINAL_ROUNDS = sip24_pkg::DEF_FINAL_ROUNDS
) (
   input  logic        clock,
   input  logic        reset,

   // Message word stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [63:0] message_word, [67:64] byte_count, [71:68] zero padding
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,

   // Digest stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [63:0] digest
   output logic [63:0] rsp_tdata,

   // Key register writes.
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [63:0] csr_wdata
);

   localparam int WORD_W = sip24_pkg::WORD_W;
   localparam int LEN_W = sip24_pkg::LEN_W;
   localparam int RPS = sip24_pkg::ROUNDS_PER_STAGE;
   localparam int FINAL_STAGES = (FINAL_ROUNDS + RPS - 1) / RPS;

   // Absorb one block with the compression rounds.
   function automatic sip24_pkg::chain_type absorb(sip24_pkg::chain_type x,
                                                    logic [WORD_W-1:0] m);
      sip24_pkg::chain_type v;
      v = x;
      v[3] = v[3] ^ m;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
         v = sip24_pkg::sip_round(v);
      end
      v[0] = v[0] ^ m;
      return v;
   endfunction

   // Key registers.
   logic [WORD_W-1:0] key_low_ff;
   logic [WORD_W-1:0] key_high_ff;

   // Running message state.
   sip24_pkg::chain_type chain_ff;
   sip24_pkg::chain_type chain_in;
   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic in_msg_ff;
   logic in_msg_in;

   // Length block stage.
   logic b_v_ff;
   sip24_pkg::chain_type b_chain_ff;
   logic b_pad_ff;
   logic [LEN_W-1:0] b_len_ff;
   logic b_rdy;
   sip24_pkg::chain_type b_out;

   // Finalization stages.
   logic [FINAL_STAGES-1:0] f_v_ff;
   sip24_pkg::chain_type f_chain_ff [FINAL_STAGES];
   sip24_pkg::chain_type f_out [FINAL_STAGES];
   logic [FINAL_STAGES-1:0] f_rdy;

   // Output register.
   logic rsp_tvalid_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic rsp_free;
   logic [WORD_W-1:0] digest;

   // Input beat decode.
   logic req_acc;
   logic [WORD_W-1:0] word;
   logic [sip24_pkg::COUNT_W-1:0] count;
   logic full;
   logic [LEN_W-1:0] len_base;
   logic [LEN_W-1:0] len_tail;
   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] block;
   sip24_pkg::chain_type start_chain;

   assign word = req_tdata[WORD_W-1:0];
   assign count = req_tdata[WORD_W +: sip24_pkg::COUNT_W];
   assign req_acc = req_tvalid && req_tready;

   // Ready chain: a stage can load when it is empty or its content moves on.
   always_comb begin
      rsp_free = !rsp_tvalid_ff || rsp_tready;
      f_rdy[FINAL_STAGES-1] = !f_v_ff[FINAL_STAGES-1] || rsp_free;
      for (int j = FINAL_STAGES - 2; j >= 0; j--) begin
         f_rdy[j] = !f_v_ff[j] || f_rdy[j+1];
      end
      b_rdy = !b_v_ff || f_rdy[0];
   end

   assign req_tready = b_rdy;

   // Word stage: start a message if needed and absorb the word or tail block.
   always_comb begin
      start_chain[0] = key_low_ff ^ sip24_pkg::SIP_C0;
      start_chain[1] = key_high_ff ^ sip24_pkg::SIP_C1;
      start_chain[2] = key_low_ff ^ sip24_pkg::SIP_C2;
      start_chain[3] = key_high_ff ^ sip24_pkg::SIP_C3;
      if (in_msg_ff) begin
         start_chain = chain_ff;
      end
      len_base = in_msg_ff ? length_ff : '0;
      // A word that is not the last, or carries eight or more bytes, is full.
      full = !req_tlast || (count >= sip24_pkg::COUNT_W'(sip24_pkg::WORD_BYTES));
      len_tail = len_base + LEN_W'(count[2:0]);
      for (int i = 0; i < sip24_pkg::WORD_BYTES; i++) begin
         tail_mask[8*i +: 8] = (i < int'(count[2:0])) ? 8'hff : 8'h00;
      end
      if (full) begin
         block = word;
         length_in = len_base + LEN_W'(sip24_pkg::WORD_BYTES);
      end else begin
         block = {len_tail, 56'h0} | (word & tail_mask);
         length_in = len_tail;
      end
      chain_in = absorb(start_chain, block);
      in_msg_in = !req_tlast;
   end

   // Length block stage: absorb the length block after a full last word, then xor FINAL_XOR into v2.
   always_comb begin
      b_out = b_chain_ff;
      if (b_pad_ff) begin
         b_out = absorb(b_chain_ff, {b_len_ff, 56'h0});
      end
      b_out[2] = b_out[2] ^ sip24_pkg::FINAL_XOR;
   end

   // Finalization rounds, up to ROUNDS_PER_STAGE per stage.
   always_comb begin
      for (int j = 0; j < FINAL_STAGES; j++) begin
         f_out[j] = f_chain_ff[j];
         for (int r = 0; r < RPS; r++) begin
            if (j * RPS + r < FINAL_ROUNDS) begin
               f_out[j] = sip24_pkg::sip_round(f_out[j]);
            end
         end
      end
      digest = f_out[FINAL_STAGES-1][0] ^ f_out[FINAL_STAGES-1][1] ^
               f_out[FINAL_STAGES-1][2] ^ f_out[FINAL_STAGES-1][3];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
         in_msg_ff <= 1'b0;
         length_ff <= '0;
         b_v_ff <= 1'b0;
         f_v_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_addr)
               sip24_pkg::CSR_KEY_LOW: key_low_ff <= csr_wdata;
               sip24_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               default: key_low_ff <= key_low_ff;
            endcase
         end
         if (req_acc) begin
            in_msg_ff <= in_msg_in;
            length_ff <= length_in;
         end
         if (b_rdy) begin
            b_v_ff <= req_acc && req_tlast;
         end
         if (f_rdy[0]) begin
            f_v_ff[0] <= b_v_ff;
         end
         for (int j = 1; j < FINAL_STAGES; j++) begin
            if (f_rdy[j]) begin
               f_v_ff[j] <= f_v_ff[j-1];
            end
         end
         if (rsp_free) begin
            rsp_tvalid_ff <= f_v_ff[FINAL_STAGES-1];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         chain_ff <= chain_in;
      end
      if (b_rdy) begin
         b_chain_ff <= chain_in;
         b_pad_ff <= full;
         b_len_ff <= length_in;
      end
      if (f_rdy[0]) begin
         f_chain_ff[0] <= b_out;
      end
      for (int j = 1; j < FINAL_STAGES; j++) begin
         if (f_rdy[j]) begin
            f_chain_ff[j] <= f_out[j-1];
         end
      end
      if (rsp_free) begin
         rsp_data_ff <= digest;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
